// ===== src/fms_pkg.sv =====
// ---------------------------------------------------------------------------
// fms_pkg: shared types and constants of the feeder motor sequencer
// Phase codes, register indexes, controller states, and the command and
// status groups between the controller and the datapath.
// ---------------------------------------------------------------------------
package fms_pkg;

  // Field widths of the channels
  localparam int NOW_W     = 32;
  localparam int HOUR_W    = 5;
  localparam int MINUTE_W  = 6;
  localparam int ENTRY_W   = 3;
  localparam int PHASE_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Width of the interval in milliseconds (65535 * 1000 fits 26 bits)
  localparam int INTERVAL_MS_W = 26;
  localparam logic [INTERVAL_MS_W-1:0] MS_PER_SECOND = 26'd1000;

  // Register reset values
  localparam logic [15:0] INTERVAL_RESET = 16'd60;
  localparam logic [7:0]  DEBOUNCE_RESET = 8'd30;

  // "No feed yet" marker for the last fed time
  localparam logic [HOUR_W-1:0]   NONE_HOUR   = 5'd31;
  localparam logic [MINUTE_W-1:0] NONE_MINUTE = 6'd63;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_SECONDS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCHEDULE_ENABLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCHEDULE_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS      = 3'd4;

  // Motor phase
  typedef enum logic [PHASE_W-1:0] {
    PH_PRESSED  = 2'd0,
    PH_RUNNING  = 2'd1,
    PH_STOPPED  = 2'd2,
    PH_DEBOUNCE = 2'd3
  } phase_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_FINISH
  } ctrl_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture the accepted beat
    logic check;      // register time compares, clear the scan
    logic scan_step;  // read one schedule slot
    logic update;     // apply the phase chain
    logic emit;       // load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic tick;       // captured beat is a valid time tick
    logic stopped;    // motor is stopped
    logic scan_go;    // schedule scan has slots to check
    logic scan_last;  // current scan read is the last slot
  } dp_status_t;

endpackage

// ===== src/fms_if.sv =====
// ---------------------------------------------------------------------------
// fms interfaces: valid/ready channels of the feeder motor sequencer
// Tick channel, result channel and configuration write channel.
// ---------------------------------------------------------------------------
interface fms_in_if;
  import fms_pkg::*;
  logic                valid;
  logic                ready;
  logic                op;
  logic [NOW_W-1:0]    now_ms;
  logic [HOUR_W-1:0]   clock_hour;
  logic [MINUTE_W-1:0] clock_minute;
  logic                time_valid;
  logic                contact_level;
  logic [ENTRY_W-1:0]  entry_index;
  logic [HOUR_W-1:0]   entry_hour;
  logic [MINUTE_W-1:0] entry_minute;

  modport source (
    output valid, op, now_ms, clock_hour, clock_minute, time_valid, contact_level,
           entry_index, entry_hour, entry_minute,
    input  ready
  );
  modport sink (
    input  valid, op, now_ms, clock_hour, clock_minute, time_valid, contact_level,
           entry_index, entry_hour, entry_minute,
    output ready
  );
endinterface

interface fms_out_if;
  import fms_pkg::*;
  logic               valid;
  logic               ready;
  logic               motor_drive;
  logic [PHASE_W-1:0] motor_phase;
  logic               feed_started;

  modport source (output valid, motor_drive, motor_phase, feed_started, input ready);
  modport sink (input valid, motor_drive, motor_phase, feed_started, output ready);
endinterface

interface fms_cfg_if;
  import fms_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/fms_ctrl.sv =====
// ---------------------------------------------------------------------------
// fms_ctrl: sequencing controller of the feeder motor sequencer
// Steps one beat through check, slot scan, phase update and result load,
// and owns the handshakes of the tick and result channels.
// ---------------------------------------------------------------------------
module fms_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  output logic                result_valid,
  input  logic                result_ready,
  input  fms_pkg::dp_status_t status,
  output fms_pkg::dp_cmd_t    cmd
);
  import fms_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_valid;
  logic        out_valid_next;
  logic        out_free;

  assign item_ready   = (state == ST_IDLE);
  assign result_valid = out_valid;
  assign out_free     = !out_valid || result_ready;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (!status.tick) begin
          state_next = ST_FINISH;
        end else if (status.stopped && status.scan_go) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_UPDATE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold the result until taken
  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = out_valid && !result_ready;
    end
  end

endmodule

// ===== src/fms_datapath.sv =====
// ---------------------------------------------------------------------------
// fms_datapath: registers, schedule memory and phase logic
// Holds the configuration, the motor phase and timestamps, the schedule
// slots with their scan counter, and the result register.
// ---------------------------------------------------------------------------
module fms_datapath #(
  parameter int MAX_SLOTS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  fms_pkg::dp_cmd_t                cmd,
  output fms_pkg::dp_status_t             status,
  input  logic                            op,
  input  logic [fms_pkg::NOW_W-1:0]       now_ms,
  input  logic [fms_pkg::HOUR_W-1:0]      clock_hour,
  input  logic [fms_pkg::MINUTE_W-1:0]    clock_minute,
  input  logic                            time_valid,
  input  logic                            contact_level,
  input  logic [fms_pkg::ENTRY_W-1:0]     entry_index,
  input  logic [fms_pkg::HOUR_W-1:0]      entry_hour,
  input  logic [fms_pkg::MINUTE_W-1:0]    entry_minute,
  input  logic                            cfg_write,
  input  logic [fms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fms_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            motor_drive,
  output logic [fms_pkg::PHASE_W-1:0]     motor_phase,
  output logic                            feed_started
);
  import fms_pkg::*;

  localparam int AW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = ($clog2(MAX_SLOTS + 1) > 4) ? $clog2(MAX_SLOTS + 1) : 4;
  localparam int EW    = (AW > ENTRY_W) ? AW : ENTRY_W;

  // Configuration registers
  logic                     interval_enable;
  logic [15:0]              interval_seconds;
  logic                     schedule_enable;
  logic [3:0]               schedule_count;
  logic [7:0]               debounce_ms;
  logic [INTERVAL_MS_W-1:0] interval_ms;

  // Captured beat
  logic                op_q;
  logic [NOW_W-1:0]    now_q;
  logic [HOUR_W-1:0]   hour_q;
  logic [MINUTE_W-1:0] minute_q;
  logic                valid_q;
  logic                contact_q;

  // Sequencer state
  phase_t              phase;
  phase_t              phase_next;
  logic [NOW_W-1:0]    release_time;
  logic [NOW_W-1:0]    release_time_next;
  logic [NOW_W-1:0]    cycle_end_time;
  logic [NOW_W-1:0]    cycle_end_time_next;
  logic [HOUR_W-1:0]   last_fed_hour;
  logic [HOUR_W-1:0]   last_fed_hour_next;
  logic [MINUTE_W-1:0] last_fed_minute;
  logic [MINUTE_W-1:0] last_fed_minute_next;
  logic                started;
  logic                started_next;

  // Schedule memory and scan
  logic [HOUR_W-1:0]   slot_hour   [MAX_SLOTS];
  logic [MINUTE_W-1:0] slot_minute [MAX_SLOTS];
  logic [HOUR_W-1:0]   rd_hour;
  logic [MINUTE_W-1:0] rd_minute;
  logic                rd_valid;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    count_ext;
  logic [CNT_W-1:0]    n_lim;
  logic [EW-1:0]       wr_ext;
  logic                wr_ok;
  logic                sched_hit;
  logic                interval_hit;
  logic                bounce_hit;
  logic                already_fed;
  logic                start_now;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      interval_enable  <= 1'b0;
      interval_seconds <= INTERVAL_RESET;
      schedule_enable  <= 1'b0;
      schedule_count   <= 4'd0;
      debounce_ms      <= DEBOUNCE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_INTERVAL_ENABLE:  interval_enable  <= cfg_data[0];
        REG_INTERVAL_SECONDS: interval_seconds <= cfg_data;
        REG_SCHEDULE_ENABLE:  schedule_enable  <= cfg_data[0];
        REG_SCHEDULE_COUNT:   schedule_count   <= cfg_data[3:0];
        REG_DEBOUNCE_MS:      debounce_ms      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Interval in milliseconds, kept ready for the next tick
  always_ff @(posedge clk) begin
    interval_ms <= INTERVAL_MS_W'(interval_seconds) * MS_PER_SECOND;
  end

  // Capture the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= op;
      now_q     <= now_ms;
      hour_q    <= clock_hour;
      minute_q  <= clock_minute;
      valid_q   <= time_valid;
      contact_q <= contact_level;
    end
  end

  // Schedule slot write and registered scan read
  assign wr_ext = EW'(entry_index);
  assign wr_ok  = (32'(wr_ext) < 32'(MAX_SLOTS));

  always_ff @(posedge clk) begin
    if (cmd.load && op && wr_ok) begin
      slot_hour[wr_ext[AW-1:0]]   <= entry_hour;
      slot_minute[wr_ext[AW-1:0]] <= entry_minute;
    end
    if (cmd.scan_step) begin
      rd_hour   <= slot_hour[cnt[AW-1:0]];
      rd_minute <= slot_minute[cnt[AW-1:0]];
    end
  end

  // Clamp the slot count to the memory depth
  assign count_ext = CNT_W'(schedule_count);
  assign n_lim     = (32'(count_ext) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : count_ext;

  // Scan counter, read pipeline and match flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rd_valid  <= 1'b0;
      sched_hit <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_step;
      if (cmd.check) begin
        cnt       <= '0;
        sched_hit <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          cnt <= cnt + CNT_W'(1);
        end
        if (rd_valid && rd_hour == hour_q && rd_minute == minute_q) begin
          sched_hit <= 1'b1;
        end
      end
    end
  end

  // Time compares, registered ahead of the update
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      interval_hit <= (now_q - cycle_end_time) >= NOW_W'(interval_ms);
      bounce_hit   <= (now_q - release_time) > NOW_W'(debounce_ms);
    end
  end

  // Phase chain: stopped, running, pressed, debouncing
  assign already_fed = (hour_q == last_fed_hour) && (minute_q == last_fed_minute);
  assign start_now   = (interval_enable && interval_hit) || (sched_hit && !already_fed);

  always_comb begin
    phase_next           = phase;
    release_time_next    = release_time;
    cycle_end_time_next  = cycle_end_time;
    last_fed_hour_next   = last_fed_hour;
    last_fed_minute_next = last_fed_minute;
    started_next         = 1'b0;
    if (phase == PH_STOPPED) begin
      if (sched_hit && !already_fed) begin
        last_fed_hour_next   = hour_q;
        last_fed_minute_next = minute_q;
      end
      if (start_now) begin
        phase_next   = PH_RUNNING;
        started_next = 1'b1;
      end
    end
    if (phase_next == PH_RUNNING && !contact_q) begin
      phase_next = PH_PRESSED;
    end
    // A freshly released contact has zero elapsed time, so it enters debounce and cannot leave it in the same update
    if (phase_next == PH_PRESSED && contact_q) begin
      release_time_next = now_q;
      phase_next        = PH_DEBOUNCE;
    end else if (phase_next == PH_DEBOUNCE && bounce_hit) begin
      if (contact_q) begin
        cycle_end_time_next = now_q;
        phase_next          = PH_STOPPED;
      end else begin
        phase_next = PH_PRESSED;
      end
    end
  end

  // Sequencer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_STOPPED;
      release_time    <= '0;
      cycle_end_time  <= '0;
      last_fed_hour   <= NONE_HOUR;
      last_fed_minute <= NONE_MINUTE;
      started         <= 1'b0;
    end else begin
      if (cmd.load) begin
        started <= 1'b0;
      end else if (cmd.update) begin
        phase           <= phase_next;
        release_time    <= release_time_next;
        cycle_end_time  <= cycle_end_time_next;
        last_fed_hour   <= last_fed_hour_next;
        last_fed_minute <= last_fed_minute_next;
        started         <= started_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      motor_drive  <= (phase != PH_STOPPED);
      motor_phase  <= phase;
      feed_started <= started;
    end
  end

  // Status to the controller
  assign status.tick      = !op_q && valid_q;
  assign status.stopped   = (phase == PH_STOPPED);
  assign status.scan_go   = schedule_enable && (n_lim != '0);
  assign status.scan_last = (cnt == n_lim - CNT_W'(1));

endmodule

// ===== src/feeder_motor_sequencer.sv =====
// Steps: check, a scan of N slots with a drain step (N = checked slots, up to MAX_SLOTS,
// scanned only while the motor is stopped), phase update, result load; other valid ticks
// skip the scan and drain, schedule writes and invalid ticks go from check to the load.
// Throughput: one beat at a time; the next beat is taken the cycle after the result loads,
// and a result held by the sink stalls the following beat in its final step.
// Reset (rst, synchronous): motor stopped, registers to defaults, no fed time; slots kept.
// ---------------------------------------------------------------------------
// feeder_motor_sequencer: feeder motor revolution sequencer
// Starts a feeding revolution on interval or schedule, runs it to the cam
// contact and stops after a debounced release.
// ---------------------------------------------------------------------------
module feeder_motor_sequencer #(
  parameter int MAX_SLOTS = 8
) (
  input  logic     clk,
  input  logic     rst,
  fms_in_if.sink   feed_item,
  fms_out_if.source feed_result,
  fms_cfg_if.sink  cfg
);
  import fms_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       cfg_write;

  // Configuration writes are always accepted and registered directly
  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid;

  fms_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (feed_item.valid),
    .item_ready   (feed_item.ready),
    .result_valid (feed_result.valid),
    .result_ready (feed_result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  fms_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .op            (feed_item.op),
    .now_ms        (feed_item.now_ms),
    .clock_hour    (feed_item.clock_hour),
    .clock_minute  (feed_item.clock_minute),
    .time_valid    (feed_item.time_valid),
    .contact_level (feed_item.contact_level),
    .entry_index   (feed_item.entry_index),
    .entry_hour    (feed_item.entry_hour),
    .entry_minute  (feed_item.entry_minute),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .motor_drive   (feed_result.motor_drive),
    .motor_phase   (feed_result.motor_phase),
    .feed_started  (feed_result.feed_started)
  );

`ifndef SYNTHESIS
  // One beat in flight: accepting drops ready on the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    feed_item.valid && feed_item.ready |=> !feed_item.ready)
    else $error("tick channel accepted a second beat while busy");

  // A result load always raises result valid
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> feed_result.valid)
    else $error("result load did not raise valid");

  // Drive follows the phase
  a_drive_phase: assert property (@(posedge clk) disable iff (rst)
    feed_result.valid |->
      feed_result.motor_drive == (feed_result.motor_phase != PH_STOPPED))
    else $error("motor drive disagrees with phase");

  // A started feed never reports a stopped motor
  a_start_running: assert property (@(posedge clk) disable iff (rst)
    feed_result.valid && feed_result.feed_started |->
      feed_result.motor_phase != PH_STOPPED)
    else $error("feed started but motor stopped");
`endif

endmodule

// ===== sim/tb.sv =====
// ---------------------------------------------------------------------------
// tb: testbench of the feeder motor sequencer
// Drives time ticks and schedule writes through the tick channel, changes
// the registers between stretches of traffic, and checks every status beat
// against a cycle-free model of the motor phases kept in this file.
// ---------------------------------------------------------------------------
module tb;
  import fms_pkg::*;

  localparam logic OP_TICK       = 1'b0;
  localparam logic OP_SLOT_WRITE = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SLOT_COUNT   = 8;
  localparam int RANDOM_ROUNDS = 8;
  localparam int ROUND_BEATS  = 88;
  localparam int SETTLE_CYCLES = 20;
  localparam int LIMIT_CYCLES = 300000;

  typedef struct packed {
    logic                op;
    logic [NOW_W-1:0]    now_ms;
    logic [HOUR_W-1:0]   clock_hour;
    logic [MINUTE_W-1:0] clock_minute;
    logic                time_valid;
    logic                contact_level;
    logic [ENTRY_W-1:0]  entry_index;
    logic [HOUR_W-1:0]   entry_hour;
    logic [MINUTE_W-1:0] entry_minute;
  } tick_beat_t;

  typedef struct packed {
    logic   motor_drive;
    phase_t motor_phase;
    logic   feed_started;
  } motor_status_t;

  logic clk = 1'b0;
  logic rst;

  fms_in_if  feed_in ();
  fms_out_if feed_out ();
  fms_cfg_if cfg_bus ();

  feeder_motor_sequencer #(.MAX_SLOTS(SLOT_COUNT)) dut (
    .clk        (clk),
    .rst        (rst),
    .feed_item  (feed_in),
    .feed_result(feed_out),
    .cfg        (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copy of the motor model
  logic        int_enable;
  logic [15:0] int_seconds;
  logic        sched_enable;
  logic [3:0]  sched_count;
  logic [7:0]  debounce_limit;

  // Motor model state
  phase_t              motor_phase_now;
  logic [NOW_W-1:0]    released_at;
  logic [NOW_W-1:0]    cycle_end_at;
  logic [HOUR_W-1:0]   fed_hour;
  logic [MINUTE_W-1:0] fed_minute;
  logic [HOUR_W-1:0]   slot_hour [SLOT_COUNT];
  logic [MINUTE_W-1:0] slot_minute [SLOT_COUNT];

  // Stimulus generator state: wall clock, cam contact and planned slots
  logic [NOW_W-1:0]    sim_clock_ms;
  logic [HOUR_W-1:0]   wall_hour;
  logic [MINUTE_W-1:0] wall_minute;
  logic                cam_level;
  int                  cam_ticks_left;
  logic [HOUR_W-1:0]   plan_hour [SLOT_COUNT];
  logic [MINUTE_W-1:0] plan_minute [SLOT_COUNT];

  tick_beat_t    tick_backlog [$];
  motor_status_t expected_status [$];
  tick_beat_t    on_bus;
  logic          holding = 1'b0;
  logic          beat_taken = 1'b0;
  int            src_idle = 0;
  int            sink_idle = 0;
  int            idle_pct = 12;
  logic          calm = 1'b0;
  int            fail_count = 0;
  int            cycle_count = 0;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < 40)
      $display("%0t: mismatch on %s: got %0d, want %0d", $time, field, got, want);
    fail_count++;
  endtask

  // Advance the motor model by one beat and return the status it reports
  function automatic motor_status_t advance_motor(input tick_beat_t b);
    motor_status_t st;
    logic          started;
    logic [31:0]   since_end;
    logic [31:0]   wait_ms;
    logic [31:0]   since_release;
    int            n;
    started = 1'b0;
    if (b.op == OP_SLOT_WRITE) begin
      slot_hour[b.entry_index] = b.entry_hour;
      slot_minute[b.entry_index] = b.entry_minute;
    end else if (b.time_valid) begin
      if (motor_phase_now == PH_STOPPED) begin
        since_end = b.now_ms - cycle_end_at;
        wait_ms = 32'(int_seconds) * 32'd1000;
        if (int_enable && since_end >= wait_ms) begin
          motor_phase_now = PH_RUNNING;
          started = 1'b1;
        end
        if (sched_enable) begin
          n = (sched_count > SLOT_COUNT) ? SLOT_COUNT : int'(sched_count);
          for (int i = 0; i < n; i++) begin
            if (b.clock_hour == slot_hour[i] && b.clock_minute == slot_minute[i] &&
                !(b.clock_hour == fed_hour && b.clock_minute == fed_minute)) begin
              motor_phase_now = PH_RUNNING;
              started = 1'b1;
              fed_hour = b.clock_hour;
              fed_minute = b.clock_minute;
            end
          end
        end
      end
      if (motor_phase_now == PH_RUNNING && !b.contact_level)
        motor_phase_now = PH_PRESSED;
      if (motor_phase_now == PH_PRESSED && b.contact_level) begin
        released_at = b.now_ms;
        motor_phase_now = PH_DEBOUNCE;
      end
      since_release = b.now_ms - released_at;
      if (motor_phase_now == PH_DEBOUNCE && since_release > 32'(debounce_limit)) begin
        if (b.contact_level) begin
          cycle_end_at = b.now_ms;
          motor_phase_now = PH_STOPPED;
        end else begin
          motor_phase_now = PH_PRESSED;
        end
      end
    end
    st.motor_drive = (motor_phase_now != PH_STOPPED);
    st.motor_phase = motor_phase_now;
    st.feed_started = started;
    return st;
  endfunction

  task automatic queue_tick(input logic [NOW_W-1:0] t, input logic [HOUR_W-1:0] h,
                            input logic [MINUTE_W-1:0] m, input logic v, input logic c);
    tick_beat_t b;
    b = '0;
    b.op = OP_TICK;
    b.now_ms = t;
    b.clock_hour = h;
    b.clock_minute = m;
    b.time_valid = v;
    b.contact_level = c;
    tick_backlog.push_back(b);
  endtask

  task automatic queue_slot(input logic [ENTRY_W-1:0] idx, input logic [HOUR_W-1:0] h,
                            input logic [MINUTE_W-1:0] m);
    tick_beat_t b;
    b = '0;
    b.op = OP_SLOT_WRITE;
    b.entry_index = idx;
    b.entry_hour = h;
    b.entry_minute = m;
    plan_hour[idx] = h;
    plan_minute[idx] = m;
    tick_backlog.push_back(b);
  endtask

  // Build one random beat: mostly ticks of a running wall clock and a
  // turning cam, now and then a schedule write
  function automatic tick_beat_t next_random_beat();
    tick_beat_t b;
    int         k;
    int         j;
    b.now_ms = $urandom();
    b.clock_hour = HOUR_W'($urandom_range(0, 31));
    b.clock_minute = MINUTE_W'($urandom_range(0, 63));
    b.time_valid = 1'($urandom_range(0, 1));
    b.contact_level = 1'($urandom_range(0, 1));
    b.entry_index = ENTRY_W'($urandom_range(0, 7));
    b.entry_hour = ($urandom_range(0, 99) < 80) ? HOUR_W'($urandom_range(0, 23)) :
                   HOUR_W'($urandom_range(0, 31));
    b.entry_minute = ($urandom_range(0, 99) < 80) ? MINUTE_W'($urandom_range(0, 59)) :
                     MINUTE_W'($urandom_range(0, 63));
    if ($urandom_range(0, 99) < 5) begin
      b.op = OP_SLOT_WRITE;
      plan_hour[b.entry_index] = b.entry_hour;
      plan_minute[b.entry_index] = b.entry_minute;
      return b;
    end
    b.op = OP_TICK;
    // advance the millisecond clock, with rare jumps across the wrap
    k = $urandom_range(0, 99);
    if (k < 70)      sim_clock_ms += $urandom_range(1, 40);
    else if (k < 90) sim_clock_ms += $urandom_range(41, 400);
    else if (k < 98) sim_clock_ms += $urandom_range(500, 3000);
    else             sim_clock_ms += $urandom();
    // move the wall clock, mostly onto planned slot times
    if ($urandom_range(0, 99) < 20) begin
      k = $urandom_range(0, 99);
      if (k < 60) begin
        j = $urandom_range(0, SLOT_COUNT - 1);
        wall_hour = plan_hour[j];
        wall_minute = plan_minute[j];
      end else if (k < 95) begin
        wall_hour = HOUR_W'($urandom_range(0, 23));
        wall_minute = MINUTE_W'($urandom_range(0, 59));
      end else begin
        wall_hour = HOUR_W'($urandom_range(0, 31));
        wall_minute = MINUTE_W'($urandom_range(0, 63));
      end
    end
    // turn the cam: runs of pressed and released with some bounce
    if (cam_ticks_left <= 0) begin
      cam_level = ~cam_level;
      cam_ticks_left = $urandom_range(1, 6);
    end
    cam_ticks_left--;
    b.now_ms = sim_clock_ms;
    b.clock_hour = wall_hour;
    b.clock_minute = wall_minute;
    b.time_valid = ($urandom_range(0, 99) < 92);
    b.contact_level = ($urandom_range(0, 99) < 5) ? ~cam_level : cam_level;
    return b;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    case (idx)
      REG_INTERVAL_ENABLE:  int_enable = val[0];
      REG_INTERVAL_SECONDS: int_seconds = val;
      REG_SCHEDULE_ENABLE:  sched_enable = val[0];
      REG_SCHEDULE_COUNT:   sched_count = val[3:0];
      REG_DEBOUNCE_MS:      debounce_limit = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic write_all_regs(input logic ie, input logic [15:0] isec, input logic se,
                                input logic [3:0] sc, input logic [7:0] db);
    write_reg(REG_INTERVAL_ENABLE, 16'(ie));
    write_reg(REG_INTERVAL_SECONDS, isec);
    write_reg(REG_SCHEDULE_ENABLE, 16'(se));
    write_reg(REG_SCHEDULE_COUNT, 16'(sc));
    write_reg(REG_DEBOUNCE_MS, 16'(db));
  endtask

  // Hold until every queued beat is taken and every status beat is back
  task automatic wait_drained();
    while (tick_backlog.size() != 0 || expected_status.size() != 0 || holding)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Tick channel driver: present queued beats, with idle bursts between them
  always @(negedge clk) begin
    logic next_valid;
    next_valid = 1'b0;
    if (!rst) begin
      if (beat_taken) begin
        beat_taken = 1'b0;
        holding = 1'b0;
      end
      if (holding) begin
        next_valid = 1'b1;
      end else if (src_idle > 0) begin
        src_idle--;
      end else if (tick_backlog.size() != 0) begin
        if (!calm && $urandom_range(0, 99) < idle_pct) begin
          src_idle = $urandom_range(1, 18) - 1;
        end else begin
          on_bus = tick_backlog.pop_front();
          holding = 1'b1;
          next_valid = 1'b1;
          feed_in.op <= on_bus.op;
          feed_in.now_ms <= on_bus.now_ms;
          feed_in.clock_hour <= on_bus.clock_hour;
          feed_in.clock_minute <= on_bus.clock_minute;
          feed_in.time_valid <= on_bus.time_valid;
          feed_in.contact_level <= on_bus.contact_level;
          feed_in.entry_index <= on_bus.entry_index;
          feed_in.entry_hour <= on_bus.entry_hour;
          feed_in.entry_minute <= on_bus.entry_minute;
        end
      end
    end
    feed_in.valid <= next_valid;
  end

  // Status channel receiver: stall in random bursts
  always @(negedge clk) begin
    logic next_ready;
    next_ready = 1'b1;
    if (rst) begin
      next_ready = 1'b0;
    end else if (!calm) begin
      if (sink_idle > 0) begin
        sink_idle--;
        next_ready = 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        sink_idle = $urandom_range(1, 18) - 1;
        next_ready = 1'b0;
      end
    end
    feed_out.ready <= next_ready;
  end

  // Monitor: predict on each accepted tick beat, check each status beat
  always @(posedge clk) begin
    motor_status_t want;
    if (!rst) begin
      if (feed_out.valid && feed_out.ready) begin
        if (expected_status.size() == 0) begin
          report_mismatch("unexpected status beat", 32'(feed_out.motor_phase), 32'd0);
        end else begin
          want = expected_status.pop_front();
          if (feed_out.motor_drive !== want.motor_drive)
            report_mismatch("motor_drive", 32'(feed_out.motor_drive), 32'(want.motor_drive));
          if (feed_out.motor_phase !== want.motor_phase)
            report_mismatch("motor_phase", 32'(feed_out.motor_phase), 32'(want.motor_phase));
          if (feed_out.feed_started !== want.feed_started)
            report_mismatch("feed_started", 32'(feed_out.feed_started),
                            32'(want.feed_started));
        end
      end
      if (feed_in.valid && feed_in.ready) begin
        expected_status.push_back(advance_motor(on_bus));
        beat_taken = 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("feeder_motor_sequencer test failed");
      $finish;
    end
  end

  initial begin
    logic        ie;
    logic [15:0] isec;
    logic        se;
    logic [3:0]  sc;
    logic [7:0]  db;
    int          k;

    // known values on every input from the start
    rst = 1'b1;
    feed_in.valid = 1'b0;
    feed_in.op = OP_TICK;
    feed_in.now_ms = '0;
    feed_in.clock_hour = '0;
    feed_in.clock_minute = '0;
    feed_in.time_valid = 1'b0;
    feed_in.contact_level = 1'b1;
    feed_in.entry_index = '0;
    feed_in.entry_hour = '0;
    feed_in.entry_minute = '0;
    feed_out.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;

    // model after reset
    int_enable = 1'b0;
    int_seconds = INTERVAL_RESET;
    sched_enable = 1'b0;
    sched_count = '0;
    debounce_limit = DEBOUNCE_RESET;
    motor_phase_now = PH_STOPPED;
    released_at = '0;
    cycle_end_at = '0;
    fed_hour = NONE_HOUR;
    fed_minute = NONE_MINUTE;
    cam_level = 1'b1;
    cam_ticks_left = 0;
    wall_hour = '0;
    wall_minute = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset registers: invalid time, fill every slot, a tick at the wrap edge
    queue_tick(32'd0, 5'd0, 6'd0, 1'b0, 1'b1);
    queue_slot(3'd0, 5'd0, 6'd0);
    queue_slot(3'd1, 5'd23, 6'd59);
    queue_slot(3'd2, 5'd12, 6'd30);
    queue_slot(3'd3, 5'd7, 6'd15);
    queue_slot(3'd4, 5'd16, 6'd1);
    queue_slot(3'd5, 5'd1, 6'd32);
    queue_slot(3'd6, 5'd22, 6'd45);
    queue_slot(3'd7, 5'd31, 6'd63);
    queue_tick(32'hFFFF_FFFF, 5'd31, 6'd63, 1'b1, 1'b0);
    wait_drained();

    // Schedule only, count past the slot number, no debounce
    write_all_regs(1'b0, 16'hFFFF, 1'b1, 4'd12, 8'd0);
    write_reg(REG_UNUSED, 16'hFFFF);
    queue_tick(32'd100, 5'd31, 6'd63, 1'b1, 1'b1);   // clock equals the none marker
    queue_tick(32'd110, 5'd23, 6'd59, 1'b1, 1'b1);   // scheduled start
    queue_tick(32'd120, 5'd23, 6'd59, 1'b1, 1'b0);
    queue_tick(32'd130, 5'd23, 6'd59, 1'b1, 1'b1);
    queue_tick(32'd131, 5'd23, 6'd59, 1'b1, 1'b1);
    queue_tick(32'd140, 5'd23, 6'd59, 1'b1, 1'b1);   // same minute, already fed
    queue_tick(32'd150, 5'd0, 6'd0, 1'b1, 1'b0);     // start and press in one tick
    queue_tick(32'd160, 5'd0, 6'd0, 1'b1, 1'b1);
    queue_tick(32'd170, 5'd0, 6'd0, 1'b1, 1'b0);     // bounce back to pressed
    queue_tick(32'd180, 5'd0, 6'd0, 1'b0, 1'b1);
    wait_drained();

    // Zero interval, longest debounce, times across the wrap
    write_reg(REG_INTERVAL_ENABLE, 16'd1);
    write_reg(REG_INTERVAL_SECONDS, 16'd0);
    write_reg(REG_SCHEDULE_ENABLE, 16'd0);
    write_reg(REG_DEBOUNCE_MS, 16'd255);
    queue_tick(32'hFFFF_FFF0, 5'd5, 6'd5, 1'b1, 1'b1);
    queue_tick(32'h0000_00F0, 5'd5, 6'd5, 1'b1, 1'b1);
    queue_tick(32'h0000_00F0, 5'd5, 6'd5, 1'b1, 1'b1);
    queue_tick(32'h0000_00F5, 5'd5, 6'd5, 1'b1, 1'b0);
    queue_tick(32'h0000_01F5, 5'd5, 6'd5, 1'b1, 1'b1);
    wait_drained();

    // Random rounds, each with its own register setting and idle rate
    sim_clock_ms = 32'h0000_0200;
    for (int p = 0; p < RANDOM_ROUNDS; p++) begin
      case (p)
        0: begin ie = 1'b1; isec = 16'hFFFF; se = 1'b1; sc = 4'd8;  db = 8'd255; end
        1: begin ie = 1'b1; isec = 16'd0;    se = 1'b0; sc = 4'd0;  db = 8'd0;   end
        2: begin ie = 1'b0; isec = 16'd60;   se = 1'b1; sc = 4'd8;  db = 8'd30;  end
        3: begin ie = 1'b1; isec = 16'd1;    se = 1'b1; sc = 4'd15; db = 8'd20;  end
        default: begin
          ie = ($urandom_range(0, 99) < 75);
          k = $urandom_range(0, 4);
          isec = (k == 4) ? 16'hFFFF : 16'($urandom_range(0, 2 * k));
          se = 1'($urandom_range(0, 1));
          sc = 4'($urandom_range(0, 8));
          db = 8'($urandom_range(0, 60));
        end
      endcase
      idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 25 : 8);
      calm = (p == RANDOM_ROUNDS - 1);
      write_all_regs(ie, isec, se, sc, db);
      for (int i = 0; i < ROUND_BEATS; i++)
        tick_backlog.push_back(next_random_beat());
      wait_drained();
    end

    if (fail_count == 0)
      $display("feeder_motor_sequencer test passed");
    else
      $display("feeder_motor_sequencer test failed");
    $finish;
  end

endmodule
